// ===== rtl/swcc_pkg.sv =====
package swcc_pkg;

  localparam int unsigned CFG_AW = 4;

  typedef enum logic [1:0] {
    REG_ALLOW_NEG = 2'd0,
    REG_ROLLOVER  = 2'd1,
    REG_ATMOS     = 2'd2,
    REG_GRAVITY   = 2'd3
  } reg_idx_t;

  localparam logic [31:0] ATMOS_RESET   = 32'd25939200;
  localparam logic [19:0] GRAVITY_RESET = 20'd642908;

  typedef struct packed {
    logic        allow_negative;
    logic [31:0] rollover_width;
    logic [31:0] atmos_pressure;
    logic [19:0] gravity_down;
  } cfg_t;

  localparam int unsigned CM_W  = 56;
  localparam int unsigned DEN_W = 44;
  localparam int unsigned DPE_W = 33;
  localparam int unsigned FAC_W = 32;
  localparam int unsigned QW    = 48;

  localparam logic [47:0] WC_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] WC_NEG_MAG = 48'h8000_0000_0000;

endpackage

// ===== rtl/surface_water_content_per_cell_top.sv =====
// A cell passes s1, s2, the ramp divider, s3, the multipliers, pr, the content divider
// and the output register; done marks its result on the result ports for one cycle.
// Throughput: one cell per cycle; busy stays low. Depth is set by the 32-stage ramp
// divider and the 48-stage content and slope dividers, one quotient bit per stage.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
module surface_water_content_per_cell_top import swcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  logic [31:0]       pressure,
  input  logic [23:0]       molar_density,
  input  logic [23:0]       mass_density,
  input  logic [31:0]       cell_area,
  output logic [47:0]       water_content,
  output logic [31:0]       content_slope,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned LAT = 87;
  localparam int unsigned P1W = CM_W + DPE_W;
  localparam int unsigned P2W = CM_W + FAC_W;
  localparam int unsigned RPW = CM_W + DEN_W + 1 + 32;

  cfg_t cfg;

  swcc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign busy = 1'b0;

  // front: pressure offset and the two plain products
  logic             s1_valid, s1_below;
  logic [31:0]      s1_mag;
  logic [CM_W-1:0]  s1_cm;
  logic [DEN_W-1:0] s1_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_below <= pressure < cfg.atmos_pressure;
    s1_mag   <= (pressure < cfg.atmos_pressure) ? cfg.atmos_pressure - pressure
                                                : pressure - cfg.atmos_pressure;
    s1_cm    <= cell_area * molar_density;
    s1_den   <= mass_density * cfg.gravity_down;
  end

  logic             s2_valid, s2_below;
  logic [31:0]      s2_mag;
  logic [63:0]      s2_sq;
  logic [CM_W-1:0]  s2_cm;
  logic [DEN_W-1:0] s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_below <= s1_below;
    s2_mag   <= s1_mag;
    s2_sq    <= s1_mag * s1_mag;
    s2_cm    <= s1_cm;
    s2_den   <= s1_den;
  end

  // rollover ramp: dp^2/r and dp*2^32/r, both quotients below 2^32 when dp < r
  logic             rq_valid;
  logic [31:0]      rq_quo, fq_quo;
  logic [RPW-1:0]   rq_pay;

  swcc_div #(.QBITS(32), .DW(32), .PW(RPW)) u_ramp_div (
    .clk, .rst,
    .in_valid  (s2_valid),
    .in_rem    (s2_sq[63:32]),
    .in_low    (s2_sq[31:0]),
    .in_div    (cfg.rollover_width),
    .in_pay    ({s2_cm, s2_den, s2_below, s2_mag}),
    .out_valid (rq_valid),
    .out_quo   (rq_quo),
    .out_pay   (rq_pay)
  );

  swcc_div #(.QBITS(32), .DW(32), .PW(1)) u_fac_div (
    .clk, .rst,
    .in_valid  (s2_valid),
    .in_rem    (s2_mag),
    .in_low    (32'd0),
    .in_div    (cfg.rollover_width),
    .in_pay    (1'b0),
    .out_valid (),
    .out_quo   (fq_quo),
    .out_pay   ()
  );

  logic [CM_W-1:0]  r_cm;
  logic [DEN_W-1:0] r_den;
  logic             r_below;
  logic [31:0]      r_mag;
  logic [DPE_W-1:0] dpe, mag2x;
  logic [FAC_W-1:0] fac;
  logic             full, neg;

  assign {r_cm, r_den, r_below, r_mag} = rq_pay;
  assign mag2x = {r_mag, 1'b0};

  always_comb begin
    dpe  = '0;
    fac  = '0;
    full = 1'b0;
    neg  = 1'b0;
    if (cfg.allow_negative) begin
      dpe  = mag2x;
      neg  = r_below;
      full = 1'b1;
    end else if (cfg.rollover_width != '0) begin
      if (r_below) begin
        dpe = '0;
      end else if (r_mag < cfg.rollover_width) begin
        dpe = {1'b0, rq_quo};
        fac = fq_quo;
      end else begin
        dpe  = mag2x - {1'b0, cfg.rollover_width};
        full = 1'b1;
      end
    end else if (!r_below) begin
      dpe  = mag2x;
      full = 1'b1;
    end
  end

  logic             s3_valid, s3_full, s3_neg, s3_zero;
  logic [DPE_W-1:0] s3_dpe;
  logic [FAC_W-1:0] s3_fac;
  logic [CM_W-1:0]  s3_cm;
  logic [DEN_W-1:0] s3_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= rq_valid;
    end
    s3_dpe  <= dpe;
    s3_fac  <= fac;
    s3_full <= full;
    s3_neg  <= neg;
    s3_zero <= (r_den == '0);
    s3_cm   <= r_cm;
    s3_den  <= r_den;
  end

  logic             ma_valid, ma_neg, ma_zero, mb_full;
  logic [P1W-1:0]   ma_prod;
  logic [P2W-1:0]   mb_prod;
  logic [DEN_W-1:0] ma_den;
  logic [CM_W-1:0]  mb_cm;

  swcc_mul #(.AW(CM_W), .BW(DPE_W), .PW(DEN_W + 2)) u_mul_content (
    .clk, .rst,
    .in_valid  (s3_valid),
    .a         (s3_cm),
    .b         (s3_dpe),
    .in_pay    ({s3_neg, s3_zero, s3_den}),
    .out_valid (ma_valid),
    .prod      (ma_prod),
    .out_pay   ({ma_neg, ma_zero, ma_den})
  );

  swcc_mul #(.AW(CM_W), .BW(FAC_W), .PW(CM_W + 1)) u_mul_slope (
    .clk, .rst,
    .in_valid  (s3_valid),
    .a         (s3_cm),
    .b         (s3_fac),
    .in_pay    ({s3_full, s3_cm}),
    .out_valid (),
    .prod      (mb_prod),
    .out_pay   ({mb_full, mb_cm})
  );

  // set up both final divisions: overflow check and the upper remainder
  logic [P2W-1:0] p2;
  logic [47:0]    d2;

  assign p2 = mb_full ? {mb_cm, 32'd0} : mb_prod;
  assign d2 = {ma_den, 4'd0};

  logic        pr_valid, pr_neg, pr_zero, pr_over1, pr_over2;
  logic [47:0] pr_rem1, pr_low1, pr_den, pr_rem2, pr_low2, pr_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else begin
      pr_valid <= ma_valid;
    end
    pr_neg   <= ma_neg;
    pr_zero  <= ma_zero;
    pr_over1 <= ma_prod[P1W-1:37] >= {8'd0, ma_den};
    pr_rem1  <= ma_prod[84:37];
    pr_low1  <= {ma_prod[36:0], 11'd0};
    pr_den   <= {4'd0, ma_den};
    pr_over2 <= {8'd0, p2[P2W-1:48]} >= d2;
    pr_rem2  <= {8'd0, p2[P2W-1:48]};
    pr_low2  <= p2[47:0];
    pr_d2    <= d2;
  end

  logic          qa_valid, qa_neg, qa_zero, qa_over, qb_over;
  logic [QW-1:0] qa, qb;

  swcc_div #(.QBITS(QW), .DW(48), .PW(3)) u_content_div (
    .clk, .rst,
    .in_valid  (pr_valid),
    .in_rem    (pr_rem1),
    .in_low    (pr_low1),
    .in_div    (pr_den),
    .in_pay    ({pr_neg, pr_zero, pr_over1}),
    .out_valid (qa_valid),
    .out_quo   (qa),
    .out_pay   ({qa_neg, qa_zero, qa_over})
  );

  swcc_div #(.QBITS(QW), .DW(48), .PW(1)) u_slope_div (
    .clk, .rst,
    .in_valid  (pr_valid),
    .in_rem    (pr_rem2),
    .in_low    (pr_low2),
    .in_div    (pr_d2),
    .in_pay    (pr_over2),
    .out_valid (),
    .out_quo   (qb),
    .out_pay   (qb_over)
  );

  // saturate, then apply sign
  logic [47:0] cap, mag_sat;
  logic        out_neg;

  assign cap     = qa_neg ? WC_NEG_MAG : WC_POS_MAX;
  assign mag_sat = (qa_over || qa > cap) ? cap : qa;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= qa_valid;
    end
    out_neg <= qa_neg & ~qa_zero;
    if (qa_zero) begin
      water_content <= '0;
      content_slope <= '0;
    end else begin
      water_content <= qa_neg ? 48'(-mag_sat) : mag_sat;
      content_slope <= (qb_over || qb[47:32] != '0) ? 32'hFFFF_FFFF : qb[31:0];
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a start at the pipeline depth");

  a_rem1: assert property (@(posedge clk) disable iff (rst)
    (pr_valid && !pr_over1) |-> (pr_rem1 < pr_den))
    else $error("content division starts with remainder not below divisor");

  a_rem2: assert property (@(posedge clk) disable iff (rst)
    (pr_valid && !pr_over2) |-> (pr_rem2 < pr_d2))
    else $error("slope division starts with remainder not below divisor");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    (done && !out_neg) |-> !water_content[47])
    else $error("nonnegative content came out negative");

endmodule

// ===== rtl/swcc_regs.sv =====
module swcc_regs import swcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr;
  reg_idx_t idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.allow_negative <= 1'b0;
      cfg.rollover_width <= '0;
      cfg.atmos_pressure <= ATMOS_RESET;
      cfg.gravity_down   <= GRAVITY_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_ALLOW_NEG: cfg.allow_negative <= pwdata[0];
        REG_ROLLOVER:  cfg.rollover_width <= pwdata;
        REG_ATMOS:     cfg.atmos_pressure <= pwdata;
        REG_GRAVITY:   cfg.gravity_down   <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ALLOW_NEG: prdata = {31'd0, cfg.allow_negative};
      REG_ROLLOVER:  prdata = cfg.rollover_width;
      REG_ATMOS:     prdata = cfg.atmos_pressure;
      REG_GRAVITY:   prdata = {12'd0, cfg.gravity_down};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/swcc_div.sv =====
module swcc_div #(
  parameter int unsigned QBITS = 32,
  parameter int unsigned DW    = 32,
  parameter int unsigned PW    = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [DW-1:0]    in_rem,
  input  logic [QBITS-1:0] in_low,
  input  logic [DW-1:0]    in_div,
  input  logic [PW-1:0]    in_pay,
  output logic             out_valid,
  output logic [QBITS-1:0] out_quo,
  output logic [PW-1:0]    out_pay
);

  // one quotient bit per stage; in_rem must be below in_div
  logic [QBITS-1:0] vld;
  logic [DW-1:0]    rem     [QBITS];
  logic [DW-1:0]    dvs     [QBITS];
  logic [QBITS-1:0] low     [QBITS];
  logic [QBITS-1:0] quo     [QBITS];
  logic [PW-1:0]    pay     [QBITS];

  logic [DW-1:0]    src_rem [QBITS];
  logic [DW-1:0]    src_div [QBITS];
  logic [QBITS-1:0] src_low [QBITS];
  logic [QBITS-1:0] src_quo [QBITS];
  logic [PW-1:0]    src_pay [QBITS];
  logic [DW:0]      trial   [QBITS];
  logic [QBITS-1:0] ge;

  always_comb begin
    src_rem[0] = in_rem;
    src_div[0] = in_div;
    src_low[0] = in_low;
    src_quo[0] = '0;
    src_pay[0] = in_pay;
    for (int i = 1; i < QBITS; i++) begin
      src_rem[i] = rem[i-1];
      src_div[i] = dvs[i-1];
      src_low[i] = low[i-1];
      src_quo[i] = quo[i-1];
      src_pay[i] = pay[i-1];
    end
    for (int i = 0; i < QBITS; i++) begin
      trial[i] = {src_rem[i], src_low[i][QBITS-1]};
      ge[i]    = (trial[i] >= {1'b0, src_div[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QBITS-2:0], in_valid};
    end
    for (int i = 0; i < QBITS; i++) begin
      rem[i] <= ge[i] ? DW'(trial[i] - {1'b0, src_div[i]}) : trial[i][DW-1:0];
      dvs[i] <= src_div[i];
      low[i] <= {src_low[i][QBITS-2:0], 1'b0};
      quo[i] <= {src_quo[i][QBITS-2:0], ge[i]};
      pay[i] <= src_pay[i];
    end
  end

  assign out_valid = vld[QBITS-1];
  assign out_quo   = quo[QBITS-1];
  assign out_pay   = pay[QBITS-1];

endmodule

// ===== rtl/swcc_mul.sv =====
module swcc_mul #(
  parameter int unsigned AW = 56,
  parameter int unsigned BW = 33,
  parameter int unsigned PW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  input  logic [PW-1:0]      in_pay,
  output logic               out_valid,
  output logic [AW+BW-1:0]   prod,
  output logic [PW-1:0]      out_pay
);

  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned RW = AW + BW;

  logic              v1;
  logic [PW-1:0]     pay1;
  logic [AL+BL-1:0]  pp_ll;
  logic [AL+BH-1:0]  pp_lh;
  logic [AH+BL-1:0]  pp_hl;
  logic [AH+BH-1:0]  pp_hh;

  // partial products first, then the weighted sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
    pp_ll   <= a[AL-1:0]  * b[BL-1:0];
    pp_lh   <= a[AL-1:0]  * b[BW-1:BL];
    pp_hl   <= a[AW-1:AL] * b[BL-1:0];
    pp_hh   <= a[AW-1:AL] * b[BW-1:BL];
    pay1    <= in_pay;
    prod    <= RW'(pp_ll) + (RW'(pp_lh) << BL) + (RW'(pp_hl) << AL)
             + (RW'(pp_hh) << (AL + BL));
    out_pay <= pay1;
  end

endmodule
